@@ src/mrnp_pkg.sv @@
// Shared types, character codes and limits for the multi-radix number parser.
package mrnp_pkg;

    // Parser phase, one-hot
    typedef enum logic [8:0] {
        PH_IDLE      = 9'b000000001,
        PH_SKIP      = 9'b000000010,
        PH_ZERO      = 9'b000000100,
        PH_HEX_START = 9'b000001000,
        PH_HEX       = 9'b000010000,
        PH_OCT       = 9'b000100000,
        PH_BIN_START = 9'b001000000,
        PH_BIN       = 9'b010000000,
        PH_DEC       = 9'b100000000
    } phase_t;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_B  = 8'h62;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    // Overflow guards and limits
    localparam logic [31:0] DEC_LIMIT = 32'd429496729;
    localparam logic [31:0] HEX_GUARD = 32'hf0000000;
    localparam logic [31:0] OCT_GUARD = 32'he0000000;
    localparam logic [31:0] BIN_GUARD = 32'h80000000;
    localparam logic [31:0] ALL_ONES  = 32'hffffffff;
    localparam logic [7:0]  POS_MAX   = 8'hff;

    // Next state and result of one parser step
    typedef struct packed {
        phase_t      phase;
        logic [31:0] acc;
        logic [7:0]  pos;
        logic        emit;
        logic [31:0] value;
        logic [1:0]  status;
        logic [7:0]  end_pos;
    } step_t;

    // Hex digit decode: {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

@@ src/mrnp_step.sv @@
// One parser step: next phase, accumulator, position and result for a character.
module mrnp_step (
    input  logic                 first,
    input  logic [7:0]           character,
    input  mrnp_pkg::phase_t     phase,
    input  logic [31:0]          acc,
    input  logic [7:0]           pos,
    output mrnp_pkg::step_t      step
);

    always_comb
    begin
        mrnp_pkg::phase_t ph;
        logic [31:0]      a;
        logic [7:0]       p;
        logic [4:0]       hd;
        logic             is_dec;
        logic             is_oct;
        logic             is_bin;
        logic [31:0]      acc_x10;

        // restart on first
        ph = first ? mrnp_pkg::PH_SKIP : phase;
        a  = first ? 32'd0 : acc;
        p  = first ? 8'd0 : pos;

        hd      = mrnp_pkg::hex_digit(character);
        is_dec  = (character >= mrnp_pkg::CH_0) && (character <= mrnp_pkg::CH_9);
        is_oct  = (character >= mrnp_pkg::CH_0) && (character <= mrnp_pkg::CH_7);
        is_bin  = (character == mrnp_pkg::CH_0) || (character == mrnp_pkg::CH_1);
        acc_x10 = {a[28:0], 3'b000} + {a[30:0], 1'b0} + {28'd0, character[3:0]};

        step.phase   = ph;
        step.acc     = a;
        step.pos     = (ph == mrnp_pkg::PH_IDLE || p == mrnp_pkg::POS_MAX) ? p : p + 8'd1;
        step.emit    = 1'b0;
        step.value   = 32'd0;
        step.status  = mrnp_pkg::ST_NONE;
        step.end_pos = 8'd0;

        unique case (ph)
            mrnp_pkg::PH_IDLE:
            begin
                step.phase = mrnp_pkg::PH_IDLE;
            end
            mrnp_pkg::PH_SKIP:
            begin
                if (character != mrnp_pkg::CH_NUL && character <= mrnp_pkg::CH_SPACE) begin
                    step.phase = mrnp_pkg::PH_SKIP;
                end else if (character == mrnp_pkg::CH_0) begin
                    step.acc   = 32'd0;
                    step.phase = mrnp_pkg::PH_ZERO;
                end else if (character == mrnp_pkg::CH_LO_B || character == mrnp_pkg::CH_UP_B) begin
                    step.acc   = 32'd0;
                    step.phase = mrnp_pkg::PH_BIN_START;
                end else if (is_dec) begin
                    step.acc   = {28'd0, character[3:0]};
                    step.phase = mrnp_pkg::PH_DEC;
                end else begin
                    step.emit = 1'b1;
                end
            end
            mrnp_pkg::PH_ZERO:
            begin
                if (character == mrnp_pkg::CH_LO_X || character == mrnp_pkg::CH_UP_X) begin
                    step.phase = mrnp_pkg::PH_HEX_START;
                end else if (is_oct) begin
                    step.acc   = {29'd0, character[2:0]};
                    step.phase = mrnp_pkg::PH_OCT;
                end else begin
                    step.emit    = 1'b1;
                    step.status  = mrnp_pkg::ST_OK;
                    step.end_pos = p;
                end
            end
            mrnp_pkg::PH_HEX_START:
            begin
                if (hd[4]) begin
                    step.acc   = {28'd0, hd[3:0]};
                    step.phase = mrnp_pkg::PH_HEX;
                end else begin
                    step.emit = 1'b1;
                end
            end
            mrnp_pkg::PH_HEX:
            begin
                if (!hd[4]) begin
                    step.emit    = 1'b1;
                    step.value   = a;
                    step.status  = mrnp_pkg::ST_OK;
                    step.end_pos = p;
                end else if ((a & mrnp_pkg::HEX_GUARD) != 32'd0) begin
                    step.emit   = 1'b1;
                    step.value  = mrnp_pkg::ALL_ONES;
                    step.status = mrnp_pkg::ST_OVF;
                end else begin
                    step.acc = {a[27:0], hd[3:0]};
                end
            end
            mrnp_pkg::PH_OCT:
            begin
                if (!is_oct) begin
                    step.emit    = 1'b1;
                    step.value   = a;
                    step.status  = mrnp_pkg::ST_OK;
                    step.end_pos = p;
                end else if ((a & mrnp_pkg::OCT_GUARD) != 32'd0) begin
                    step.emit   = 1'b1;
                    step.value  = mrnp_pkg::ALL_ONES;
                    step.status = mrnp_pkg::ST_OVF;
                end else begin
                    step.acc = {a[28:0], character[2:0]};
                end
            end
            mrnp_pkg::PH_BIN_START:
            begin
                if (is_bin) begin
                    step.acc   = {31'd0, character[0]};
                    step.phase = mrnp_pkg::PH_BIN;
                end else begin
                    step.emit = 1'b1;
                end
            end
            mrnp_pkg::PH_BIN:
            begin
                if (!is_bin) begin
                    step.emit    = 1'b1;
                    step.value   = a;
                    step.status  = mrnp_pkg::ST_OK;
                    step.end_pos = p;
                end else if ((a & mrnp_pkg::BIN_GUARD) != 32'd0) begin
                    step.emit   = 1'b1;
                    step.value  = mrnp_pkg::ALL_ONES;
                    step.status = mrnp_pkg::ST_OVF;
                end else begin
                    step.acc = {a[30:0], character[0]};
                end
            end
            mrnp_pkg::PH_DEC:
            begin
                if (!is_dec) begin
                    step.emit    = 1'b1;
                    step.value   = a;
                    step.status  = mrnp_pkg::ST_OK;
                    step.end_pos = p;
                end else if (a > mrnp_pkg::DEC_LIMIT ||
                             (a == mrnp_pkg::DEC_LIMIT && character > mrnp_pkg::CH_5)) begin
                    step.emit   = 1'b1;
                    step.value  = mrnp_pkg::ALL_ONES;
                    step.status = mrnp_pkg::ST_OVF;
                end else begin
                    step.acc = acc_x10;
                end
            end
            default:
            begin
                step.phase = mrnp_pkg::PH_IDLE;
            end
        endcase

        // every result returns the parser to idle
        if (step.emit) begin
            step.phase = mrnp_pkg::PH_IDLE;
        end
    end

endmodule

@@ src/multi_radix_number_parser.sv @@
// Top level of the streaming multi-radix unsigned number parser.
//
//   channel  | signals                               | direction
//   ---------+---------------------------------------+----------
//   char     | char_valid, char_stall, first,        | in
//            | character                             |
//   result   | result_valid, result_stall, value,    | out
//            | status, end_position                  |
//
// One character per cycle while the input is not stalled: a request lands in
// the input register, then the parser step (shift-and-add by ten for decimal,
// guard compares) updates the state and loads the result register. A result
// is valid once its character has passed the input and result registers.
// Reset clears the valid bits and puts the parser idle.
// A stalled result holds the step; the input stalls only while both registers
// are full and the result is stalled.
module multi_radix_number_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic        first,
    input  logic [7:0]  character,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] value,
    output logic [1:0]  status,
    output logic [7:0]  end_position
);

    logic              in_valid_reg;
    logic              first_reg;
    logic [7:0]        char_reg;
    mrnp_pkg::phase_t  phase_reg;
    logic [31:0]       acc_reg;
    logic [7:0]        pos_reg;
    logic              out_valid_reg;
    logic [31:0]       value_reg;
    logic [1:0]        status_reg;
    logic [7:0]        end_pos_reg;
    mrnp_pkg::step_t   step;
    logic              fire;

    // advance the held request when the result slot is free or draining
    assign fire       = in_valid_reg && (!out_valid_reg || !result_stall);
    assign char_stall = in_valid_reg && !fire;

    mrnp_step u_step (
        .first     (first_reg),
        .character (char_reg),
        .phase     (phase_reg),
        .acc       (acc_reg),
        .pos       (pos_reg),
        .step      (step)
    );

    // input register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!char_stall)
        begin
            in_valid_reg <= char_valid;
        end
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (char_valid && !char_stall)
        begin
            first_reg <= first;
            char_reg  <= character;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mrnp_pkg::PH_IDLE;
            acc_reg   <= 32'd0;
            pos_reg   <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg <= step.phase;
            acc_reg   <= step.acc;
            pos_reg   <= step.pos;
        end
    end

    // result register: valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= step.emit;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register: payload
    always_ff @(posedge clk)
    begin
        if (fire && step.emit)
        begin
            value_reg   <= step.value;
            status_reg  <= step.status;
            end_pos_reg <= step.end_pos;
        end
    end

    assign result_valid = out_valid_reg;
    assign value        = value_reg;
    assign status       = status_reg;
    assign end_position = end_pos_reg;

endmodule
